### src/i2cm_pkg.sv
// shared types and constants for the i2c master bit engine
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
   localparam int HALF_W        = 16;
   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd1000;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // command codes carried on req_tuser
   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_STOP  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   // where the sda latch takes its value from in a phase
   typedef enum logic [2:0] {
      SDA_HOLD,
      SDA_LOW,
      SDA_HIGH,
      SDA_WBIT,
      SDA_ACK
   } sda_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START_A,
      ST_START_B,
      ST_START_C,
      ST_STOP_A,
      ST_STOP_B,
      ST_STOP_C,
      ST_WR_DATA,
      ST_WR_HIGH,
      ST_WR_LOW,
      ST_WR_ACK_REL,
      ST_WR_ACK_HIGH,
      ST_WR_DONE,
      ST_RD_LOW,
      ST_RD_HIGH,
      ST_RD_END_LOW,
      ST_RD_ACK_DRIVE,
      ST_RD_ACK_HIGH,
      ST_RD_ACK_LOW
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        load;    // capture request fields
      logic        step;    // apply phase, present item, start hold timer
      logic        scl;
      sda_sel_type sda_sel;
      logic        dir;     // 1 sda released as input
      logic        last;
      logic        rd_out;  // put read byte on this item
      logic        status;
      logic        shift;   // advance write shift register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;       // hold time over and item taken
      logic slave_nack; // captured ack slot level
   } dp_sts_type;

endpackage

### src/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: sequencer plus pin datapath
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  req     | in        | req_tvalid/req_tready  | tuser command, tdata byte/ack/read bits
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata pin phase, tlast end of command
//  csr     | in        | csr_valid/csr_ready    | csr_wdata half period in clock cycles
//
//  one command item gives 3 (start, stop), 20 (read), 27 or 29 (write) phase items
//  the hold timer keeps each phase for the programmed half period, and the next phase
//  also waits until the previous phase item has been taken; rsp stalls add to that
//  one command at a time: req_tready is high only while the sequencer is idle
//  synchronous active-high reset releases scl and sda (high, sda as output) and
//  sets the half period to 1000; csr_ready is always high
//
module i2c_master_bit_engine (
   input  logic                              clock,
   input  logic                              reset,
   // slave side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // write_byte[7:0], send_ack[8], slave_ack_level[9], bus_read_bits[17:10], zero fill
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [1:0]                        req_tuser,
   // master side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scl_level[0], sda_level[1], sda_is_input[2], read_data[10:3], status[11], zero fill
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // last_phase
   output logic                              rsp_tlast,
   // half period register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [i2cm_pkg::HALF_W-1:0]       csr_wdata
);
   import i2cm_pkg::*;

   ctl_cmd_type cmd;   // phase actions from the sequencer
   dp_sts_type  sts;   // hold done and captured ack level

   i2cm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   i2cm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### src/i2cm_datapath.sv
// pin latches, request capture, phase hold timer and result register
`timescale 1ns / 1ps

module i2cm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [i2cm_pkg::HALF_W-1:0]          csr_wdata,
   input  i2cm_pkg::ctl_cmd_type                cmd,
   output i2cm_pkg::dp_sts_type                 sts,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import i2cm_pkg::*;

   logic [HALF_W-1:0]        half_ff, half_in;
   logic [HALF_W-1:0]        timer_ff, timer_in;
   logic [BITS_PER_BYTE-1:0] wshift_ff, wshift_in;
   logic [BITS_PER_BYTE-1:0] rbits_ff, rbits_in;
   logic                     send_ack_ff, send_ack_in;
   logic                     nack_ff, nack_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic                     dir_ff, dir_in;
   logic                     vld_ff, vld_in;
   logic [RSP_TDATA_W-1:0]   data_ff, data_in;
   logic                     last_ff, last_in;
   logic                     sda_next;

   assign csr_ready = 1'b1;
   assign half_in   = csr_valid ? csr_wdata : half_ff;

   always_comb begin
      unique case (cmd.sda_sel)
         SDA_HOLD: sda_next = sda_ff;
         SDA_LOW:  sda_next = 1'b0;
         SDA_HIGH: sda_next = 1'b1;
         SDA_WBIT: sda_next = wshift_ff[BITS_PER_BYTE-1];
         SDA_ACK:  sda_next = ~send_ack_ff;
         default:  sda_next = sda_ff;
      endcase
   end

   always_comb begin
      wshift_in   = wshift_ff;
      rbits_in    = rbits_ff;
      send_ack_in = send_ack_ff;
      nack_in     = nack_ff;
      if (cmd.load) begin
         wshift_in   = req_tdata[7:0];
         send_ack_in = req_tdata[8];
         nack_in     = req_tdata[9];
         rbits_in    = req_tdata[17:10];
      end else if (cmd.shift) begin
         wshift_in = {wshift_ff[BITS_PER_BYTE-2:0], 1'b0};
      end
   end

   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      dir_in   = dir_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      vld_in   = vld_ff & ~rsp_tready;
      timer_in = (timer_ff != '0) ? timer_ff - 1'b1 : timer_ff;
      if (cmd.step) begin
         scl_in   = cmd.scl;
         sda_in   = sda_next;
         dir_in   = cmd.dir;
         vld_in   = 1'b1;
         last_in  = cmd.last;
         // scl, sda, dir, read byte, status from bit 0 up
         data_in  = {4'b0000,
                     cmd.last & cmd.status,
                     (cmd.last & cmd.rd_out) ? rbits_ff : '0,
                     cmd.dir, sda_next, cmd.scl};
         timer_in = (half_ff != '0) ? half_ff - 1'b1 : '0;
      end
   end

   assign sts.done       = (timer_ff == '0) & ~vld_ff;
   assign sts.slave_nack = nack_ff;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_PERIOD_RESET;
         timer_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         dir_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         half_ff  <= half_in;
         timer_ff <= timer_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         dir_ff   <= dir_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wshift_ff   <= wshift_in;
      rbits_ff    <= rbits_in;
      send_ack_ff <= send_ack_in;
      nack_ff     <= nack_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
   end

endmodule

### src/i2cm_ctrl.sv
// phase sequencer for start, stop, write byte and read byte commands
`timescale 1ns / 1ps

module i2cm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,
   input  i2cm_pkg::dp_sts_type   sts,
   output i2cm_pkg::ctl_cmd_type  cmd
);
   import i2cm_pkg::*;

   state_type            state_ff, state_in;
   logic                 issued_ff, issued_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 status_ff, status_in;
   logic                 advance;
   logic                 accept;
   logic                 last_bit;

   assign accept   = (state_ff == ST_IDLE) & req_tvalid;
   assign advance  = issued_ff & sts.done;
   assign last_bit = (bit_cnt_ff == BIT_CNT_W'(BITS_PER_BYTE - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_kind_type'(req_tuser))
                  REQ_START: state_in = ST_START_A;
                  REQ_STOP:  state_in = ST_STOP_A;
                  REQ_WRITE: state_in = ST_WR_DATA;
                  REQ_READ:  state_in = ST_RD_LOW;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_START_A:      if (advance) state_in = ST_START_B;
         ST_START_B:      if (advance) state_in = ST_START_C;
         ST_START_C:      if (advance) state_in = ST_IDLE;
         ST_STOP_A:       if (advance) state_in = ST_STOP_B;
         ST_STOP_B:       if (advance) state_in = ST_STOP_C;
         ST_STOP_C:       if (advance) state_in = ST_IDLE;
         ST_WR_DATA:      if (advance) state_in = ST_WR_HIGH;
         ST_WR_HIGH:      if (advance) state_in = ST_WR_LOW;
         ST_WR_LOW:       if (advance) state_in = last_bit ? ST_WR_ACK_REL : ST_WR_DATA;
         ST_WR_ACK_REL:   if (advance) state_in = ST_WR_ACK_HIGH;
         ST_WR_ACK_HIGH:  if (advance) state_in = sts.slave_nack ? ST_STOP_A : ST_WR_DONE;
         ST_WR_DONE:      if (advance) state_in = ST_IDLE;
         ST_RD_LOW:       if (advance) state_in = ST_RD_HIGH;
         ST_RD_HIGH:      if (advance) state_in = last_bit ? ST_RD_END_LOW : ST_RD_LOW;
         ST_RD_END_LOW:   if (advance) state_in = ST_RD_ACK_DRIVE;
         ST_RD_ACK_DRIVE: if (advance) state_in = ST_RD_ACK_HIGH;
         ST_RD_ACK_HIGH:  if (advance) state_in = ST_RD_ACK_LOW;
         ST_RD_ACK_LOW:   if (advance) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // sequencing counters
   always_comb begin
      issued_in  = (state_ff != ST_IDLE) & ~advance;
      bit_cnt_in = bit_cnt_ff;
      status_in  = status_ff;
      if (accept) begin
         bit_cnt_in = '0;
         status_in  = 1'b0;
      end else if (advance) begin
         if ((state_ff == ST_WR_LOW) || (state_ff == ST_RD_HIGH)) begin
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
         if ((state_ff == ST_WR_ACK_HIGH) && sts.slave_nack) begin
            status_in = 1'b1;
         end
      end
   end

   // phase actions
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.load    = accept;
      cmd.step    = (state_ff != ST_IDLE) & ~issued_ff;
      cmd.scl     = 1'b0;
      cmd.sda_sel = SDA_HOLD;
      cmd.dir     = 1'b0;
      cmd.last    = 1'b0;
      cmd.rd_out  = 1'b0;
      cmd.status  = 1'b0;
      cmd.shift   = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_START_A: begin
            cmd.scl     = 1'b1;
            cmd.sda_sel = SDA_HIGH;
         end
         ST_START_B: begin
            cmd.scl     = 1'b1;
            cmd.sda_sel = SDA_LOW;
         end
         ST_START_C: begin
            cmd.last    = 1'b1;
         end
         ST_STOP_A: begin
            cmd.sda_sel = SDA_LOW;
         end
         ST_STOP_B: begin
            cmd.scl     = 1'b1;
         end
         ST_STOP_C: begin
            cmd.scl     = 1'b1;
            cmd.sda_sel = SDA_HIGH;
            cmd.last    = 1'b1;
            cmd.status  = status_ff;
         end
         ST_WR_DATA: begin
            cmd.sda_sel = SDA_WBIT;
         end
         ST_WR_HIGH: begin
            cmd.scl     = 1'b1;
         end
         ST_WR_LOW: begin
            cmd.shift   = cmd.step;
         end
         ST_WR_ACK_REL: begin
            cmd.sda_sel = SDA_HIGH;
            cmd.dir     = 1'b1;
         end
         ST_WR_ACK_HIGH: begin
            cmd.scl     = 1'b1;
            cmd.dir     = 1'b1;
         end
         ST_WR_DONE: begin
            cmd.dir     = 1'b1;
            cmd.last    = 1'b1;
         end
         ST_RD_LOW: begin
            cmd.dir     = 1'b1;
         end
         ST_RD_HIGH: begin
            cmd.scl     = 1'b1;
            cmd.dir     = 1'b1;
         end
         ST_RD_END_LOW: begin
            cmd.dir     = 1'b1;
         end
         ST_RD_ACK_DRIVE: begin
            cmd.sda_sel = SDA_ACK;
         end
         ST_RD_ACK_HIGH: begin
            cmd.scl     = 1'b1;
         end
         ST_RD_ACK_LOW: begin
            cmd.last    = 1'b1;
            cmd.rd_out  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issued_ff  <= 1'b0;
         bit_cnt_ff <= '0;
         status_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         issued_ff  <= issued_in;
         bit_cnt_ff <= bit_cnt_in;
         status_ff  <= status_in;
      end
   end

endmodule

### tb/i2c_master_bit_engine_tb.sv
// self-checking testbench for the i2c master bit engine: command stream in, pin phases out
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   localparam int CLK_HALF_NS  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 3_000_000;  // the 65535 half period part dominates this budget
   localparam int SETTLE       = 8;          // wait for the sequencer to go idle

   // one bus command as the sender sees it
   typedef struct {
      req_kind_type kind;
      logic [7:0]   wbyte;
      logic         ack_en;      // read: drive ack
      logic         slave_nack;  // write: level seen in the ack slot
      logic [7:0]   rbits;       // read: sda level at each scl high of the byte
   } command_type;

   // one pin phase as the block should present it
   typedef struct {
      logic       scl;
      logic       sda;
      logic       sda_in;
      logic       last;
      logic [7:0] rdata;
      logic       status;
   } phase_type;

   // pin-level model of the engine plus the queue of phases still owed
   class phase_tracker;
      logic      scl_q;
      logic      sda_q;
      logic      dir_q;
      phase_type phases_due[$];
      int        errors;
      int        commands;
      int        phases;

      function new();
         scl_q    = 1'b1;
         sda_q    = 1'b1;
         dir_q    = 1'b0;
         errors   = 0;
         commands = 0;
         phases   = 0;
      endfunction

      function void owe_phase(bit last, logic [7:0] rd, bit st);
         phase_type p;
         p.scl    = scl_q;
         p.sda    = sda_q;
         p.sda_in = dir_q;
         p.last   = last;
         p.rdata  = last ? rd : 8'h00;
         p.status = last ? st : 1'b0;
         phases_due.push_back(p);
      endfunction

      function void owe_stop(bit st);
         dir_q = 1'b0;
         scl_q = 1'b0;
         sda_q = 1'b0;
         owe_phase(0, 8'h00, 0);
         scl_q = 1'b1;
         owe_phase(0, 8'h00, 0);
         sda_q = 1'b1;
         owe_phase(1, 8'h00, st);
      endfunction

      // predict the phase run of one accepted command
      function void note_command(command_type c);
         commands++;
         case (c.kind)
            REQ_START: begin
               dir_q = 1'b0;
               scl_q = 1'b1;
               sda_q = 1'b1;
               owe_phase(0, 8'h00, 0);
               sda_q = 1'b0;
               owe_phase(0, 8'h00, 0);
               scl_q = 1'b0;
               owe_phase(1, 8'h00, 0);
            end
            REQ_STOP: begin
               owe_stop(0);
            end
            REQ_WRITE: begin
               dir_q = 1'b0;
               scl_q = 1'b0;
               for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
                  sda_q = c.wbyte[i];
                  owe_phase(0, 8'h00, 0);
                  scl_q = 1'b1;
                  owe_phase(0, 8'h00, 0);
                  scl_q = 1'b0;
                  owe_phase(0, 8'h00, 0);
               end
               dir_q = 1'b1;
               sda_q = 1'b1;
               owe_phase(0, 8'h00, 0);
               scl_q = 1'b1;
               owe_phase(0, 8'h00, 0);
               if (c.slave_nack) begin
                  owe_stop(1);
               end else begin
                  scl_q = 1'b0;
                  owe_phase(1, 8'h00, 0);
               end
            end
            default: begin
               dir_q = 1'b1;
               for (int i = 0; i < BITS_PER_BYTE; i++) begin
                  scl_q = 1'b0;
                  owe_phase(0, 8'h00, 0);
                  scl_q = 1'b1;
                  owe_phase(0, 8'h00, 0);
               end
               scl_q = 1'b0;
               owe_phase(0, 8'h00, 0);
               dir_q = 1'b0;
               sda_q = ~c.ack_en;
               owe_phase(0, 8'h00, 0);
               scl_q = 1'b1;
               owe_phase(0, 8'h00, 0);
               scl_q = 1'b0;
               owe_phase(1, c.rbits, 0);
            end
         endcase
      endfunction

      function void check_field(string fname, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected 'h%0h, got 'h%0h", fname, want, got);
            errors++;
         end
      endfunction

      function void check_phase(logic [RSP_TDATA_W-1:0] data, logic tlast);
         phase_type p;
         phases++;
         if (phases_due.size() == 0) begin
            $error("phase item with none expected: tdata 'h%0h tlast %0b", data, tlast);
            errors++;
         end else begin
            p = phases_due.pop_front();
            check_field("scl_level", p.scl, data[0]);
            check_field("sda_level", p.sda, data[1]);
            check_field("sda_is_input", p.sda_in, data[2]);
            check_field("read_data", p.rdata, data[10:3]);
            check_field("status", p.status, data[11]);
            check_field("last_phase", p.last, tlast);
         end
      endfunction
   endclass

   // clock and reset, every input known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [HALF_W-1:0]      csr_wdata  = '0;

   phase_tracker tracker;
   int           tx_idle_pct = 0;   // chance the sender sits out before an item
   int           rx_stall_pct = 0;  // chance the receiver holds tready low in a cycle
   int           cycles = 0;

   always #CLK_HALF_NS clock = ~clock;

   i2c_master_bit_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // receiver: random back-pressure on the phase stream
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // every phase item taken is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_phase(rsp_tdata, rsp_tlast);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d phases outstanding",
                  cycles, tracker.phases_due.size());
         $display("i2c_master_bit_engine regression: fail");
         $finish;
      end
   end

   function automatic command_type make_cmd(req_kind_type kind, logic [7:0] wbyte,
                                            logic ack_en, logic slave_nack,
                                            logic [7:0] rbits);
      command_type c;
      c.kind       = kind;
      c.wbyte      = wbyte;
      c.ack_en     = ack_en;
      c.slave_nack = slave_nack;
      c.rbits      = rbits;
      return c;
   endfunction

   // all fields random, callers overwrite what a sequence needs
   function automatic command_type random_cmd();
      return make_cmd(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
   endfunction

   // offer one command and wait for the engine to take it; valid stays up afterwards
   task automatic push_command(command_type c);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.kind;
      req_tdata  <= {6'b0, c.rbits, c.slave_nack, c.ack_en, c.wbyte};
      do @(posedge clock); while (!req_tready);
      tracker.note_command(c);
   endtask

   // sender goes quiet until every predicted phase has been taken
   task automatic drain_bus();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.phases_due.size() != 0);
   endtask

   // half period write, only with the engine idle
   task automatic set_half_period(logic [HALF_W-1:0] cycles_per_phase);
      drain_bus();
      // the final phase may still be on hold after its item was taken
      do @(posedge clock); while (!req_tready);
      csr_valid <= 1'b1;
      csr_wdata <= cycles_per_phase;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed transfers: start, address byte, data bytes, stop;
   // address lsb picks read or write, the rest is stray commands
   task automatic run_traffic(int n_items);
      int          issued;
      int          n_bytes;
      bit          reading;
      bit          aborted;
      command_type c;
      issued = 0;
      while (issued < n_items) begin
         if ($urandom_range(99) < 80) begin
            c = random_cmd();
            c.kind = REQ_START;
            push_command(c);
            c = random_cmd();
            c.kind = REQ_WRITE;
            c.slave_nack = ($urandom_range(99) < 15);
            reading = c.wbyte[0];
            aborted = c.slave_nack;   // the engine ends a nacked write with its own stop
            push_command(c);
            issued += 2;
            n_bytes = $urandom_range(1, 4);
            for (int i = 0; i < n_bytes && !aborted; i++) begin
               c = random_cmd();
               if (reading) begin
                  c.kind = REQ_READ;
                  c.ack_en = (i != n_bytes - 1);   // nack the final byte
               end else begin
                  c.kind = REQ_WRITE;
                  c.slave_nack = ($urandom_range(99) < 10);
                  aborted = c.slave_nack;
               end
               push_command(c);
               issued++;
            end
            if (!aborted) begin
               c = random_cmd();
               c.kind = REQ_STOP;
               push_command(c);
               issued++;
            end
         end else begin
            push_command(random_cmd());
            issued++;
         end
         // now and then the sender waits for the bus to go quiet
         if ($urandom_range(99) < 8) begin
            drain_bus();
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset half period: one start and stop at the default timing
      push_command(make_cmd(REQ_START, 8'hff, 1'b1, 1'b1, 8'hff));
      push_command(make_cmd(REQ_STOP, 8'h00, 1'b0, 1'b0, 8'h00));

      // directed: shortest phases, extremes of every field, every command
      set_half_period(16'd1);
      push_command(make_cmd(REQ_START, 8'h00, 1'b0, 1'b0, 8'h00));
      push_command(make_cmd(REQ_WRITE, 8'h00, 1'b1, 1'b0, 8'hff));
      push_command(make_cmd(REQ_WRITE, 8'hff, 1'b0, 1'b0, 8'h00));
      push_command(make_cmd(REQ_WRITE, 8'ha5, 1'b1, 1'b1, 8'h3c));  // no ack: stop, status set
      push_command(make_cmd(REQ_START, 8'hff, 1'b1, 1'b1, 8'hff));
      push_command(make_cmd(REQ_WRITE, 8'h5a, 1'b0, 1'b0, 8'hc3));
      push_command(make_cmd(REQ_READ, 8'h00, 1'b1, 1'b0, 8'hff));
      push_command(make_cmd(REQ_READ, 8'hff, 1'b1, 1'b1, 8'h00));
      push_command(make_cmd(REQ_READ, 8'h5a, 1'b0, 1'b1, 8'h81));   // nack
      push_command(make_cmd(REQ_STOP, 8'hff, 1'b1, 1'b1, 8'hff));
      push_command(make_cmd(REQ_STOP, 8'h00, 1'b0, 1'b0, 8'h00));   // stop on an idle bus
      push_command(make_cmd(REQ_READ, 8'h81, 1'b0, 1'b0, 8'h7e));   // read with no start
      push_command(make_cmd(REQ_WRITE, 8'hff, 1'b0, 1'b1, 8'hff));  // all ones, no ack
      push_command(make_cmd(REQ_START, 8'h00, 1'b0, 1'b0, 8'h00));
      push_command(make_cmd(REQ_START, 8'h00, 1'b0, 1'b0, 8'h00));  // repeated start
      push_command(make_cmd(REQ_WRITE, 8'h80, 1'b1, 1'b0, 8'h01));
      push_command(make_cmd(REQ_READ, 8'h7f, 1'b1, 1'b0, 8'h80));
      push_command(make_cmd(REQ_STOP, 8'h55, 1'b1, 1'b1, 8'haa));

      // longest phases: a single start
      set_half_period(16'hffff);
      push_command(make_cmd(REQ_START, 8'h00, 1'b0, 1'b0, 8'h00));

      // random traffic under each idling pattern
      set_half_period(16'd2);
      tx_idle_pct = 79;
      run_traffic(20);

      set_half_period(16'd3);
      tx_idle_pct  = 0;
      rx_stall_pct = 79;
      run_traffic(20);

      set_half_period(16'($urandom_range(4, 9)));
      tx_idle_pct  = 21;
      rx_stall_pct = 21;
      run_traffic(20);

      set_half_period(16'd1);
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      run_traffic(20);

      // let the last phases land, then look for strays
      drain_bus();
      repeat (SETTLE) @(posedge clock);

      if (tracker.phases_due.size() != 0) begin
         $error("%0d predicted phases never arrived", tracker.phases_due.size());
         tracker.errors++;
      end
      $display("ran %0d bus commands producing %0d pin phases", tracker.commands,
               tracker.phases);
      $display("half periods from 1 to 65535 cycles, with and without sender gaps and stalls");
      if (tracker.errors == 0) begin
         $display("i2c_master_bit_engine regression: pass");
      end else begin
         $display("i2c_master_bit_engine regression: fail");
      end
      $finish;
   end

endmodule
